### rtl/rwbh_pkg.sv
package rwbh_pkg;

  // One item held between the input side and the hash stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       restart;
    logic       drop_old;   // the leaving byte must be cancelled
    logic       win_full;   // the window is full after this byte
  } s1_t;

  // Fixed random word for every byte value.
  localparam logic [63:0] BYTE_TABLE [256] = '{
    64'hfead5b707dc7705c, 64'h377c1e06dc1e45cf, 64'h0184179586d5ae76, 64'hd23aa044f8193aa6,
    64'hbd8ef5fcde7bd95e, 64'h29a822b00a75ea90, 64'h5ba03c1b2fdc2f86, 64'h4f67d80bad410270,
    64'hfcc4b6b0cb67bb75, 64'h8f4359ea8777f5d0, 64'h5a110ec6371430f5, 64'he15dae4e9709aa66,
    64'hf8008efefbc29115, 64'hd667f1ec0a5bcccf, 64'hf56a2815cb29dbf8, 64'hfc684381b1846cad,
    64'h15be2b7ed5231683, 64'h0c226b1f911732c5, 64'he449b5885fd1d930, 64'hf6d86c27a242cf1d,
    64'hc45cd857fdd32ca4, 64'h36de9a99be8c3419, 64'h8c34f2ee7050433f, 64'h9fca9c3c61c05ce8,
    64'hf3727fe070e026f1, 64'h019172d2948847be, 64'h547bcbfaaef62543, 64'h97df2b9f6c70001b,
    64'h2833bcc8513a3ae8, 64'h63fb313206823b31, 64'he97ba036be16b286, 64'hdde1143e9e8f7684,
    64'hc4e0d8e6e491054c, 64'h7c488b71d4cab5fd, 64'h2e0986d1f8e2d362, 64'h97978ef2435b5cb1,
    64'h5506c42930dfc2a4, 64'h3205d4c5886673cf, 64'h22d5bfe8ba771cc5, 64'h39503d4cb89afd6b,
    64'h9fc1cad11e5b5755, 64'hce967aae1fccb3c3, 64'h0f164d18916d4043, 64'h113893188dd7e602,
    64'hedb9343bcf5f16ef, 64'h0ce3b155cfc00cbf, 64'h144c6c104492dff7, 64'he1ab67476c3c787f,
    64'h06357095472efed7, 64'h29573d1071bb1237, 64'he27e7ce26dcd54c6, 64'h03a8623e84a0e89c,
    64'h381194ea8cb4f8fe, 64'h53cbe859f67ae71c, 64'h85e08cd4432b31f5, 64'h21f9758ed837239d,
    64'h835aad64a22264b4, 64'hf83ec94f1a0159f3, 64'h016a63af376515a4, 64'h8af0e82577e30b6e,
    64'h4e3717bd197f8c8d, 64'h20193e9699604cea, 64'hfa8eb53310f65183, 64'hb4980361f9a7e3b3,
    64'hccb9771f04663244, 64'he975bed27cfd7a05, 64'h46e9eb7dd3ffd802, 64'hbe4b5af269bf4b64,
    64'hf3ff155176f34e7e, 64'hfc8e0e5c20814c3f, 64'h3910b75cbe6677f5, 64'h86fb5f8ef54ad45a,
    64'had430e08aa6aea72, 64'h6a82d96b64a7f48c, 64'h8aa8af38d787327e, 64'h3a10990b93334a3d,
    64'h010c38275c1fc3ac, 64'h03eac81f78d29425, 64'h356d5c2052ac066f, 64'h9a14a98e51d4eafc,
    64'h9c07059dac0831b5, 64'h51c3aa247abb4a6c, 64'h7f9d96a58c371a56, 64'he098fe430cedd615,
    64'h960e3a1dbe524565, 64'hf0401c427323f9e8, 64'h2c22d55a6135331c, 64'h8684f0837cb96bc9,
    64'hb7ac495220cc7e9b, 64'h4083bd84b86ad15e, 64'hd7434c89c5464bfd, 64'h6af7d49f8b658a9d,
    64'h1b9878f861dd7d00, 64'h6f5b7c3c3baaca36, 64'hab6e6179f8b69d37, 64'hda4c68dc98bcecd5,
    64'h42cb0a636ba3fa38, 64'h04f2814021d2f99a, 64'h53a069c086a24b1d, 64'hce39ccfebf0fd3cf,
    64'h6da4576c5b938392, 64'h73961a564d3684af, 64'he62079e996d934ab, 64'h0fe43a5aded65708,
    64'h8ea00b7c1ba4a6b4, 64'hb3f325b0d1acc61a, 64'hb7d68c724ee32277, 64'h8838a5a56df55c2e,
    64'h639e1a16eebc31dc, 64'hc824476623ee8713, 64'h6cfd35dd41d4a35f, 64'hc0cf8dfb2eb67ca4,
    64'h9b2db80c20bf8281, 64'h8f43090206cbc3a5, 64'hf018850ed3cce401, 64'hdd9c873dbc24dacf,
    64'h8c310f7792646b4a, 64'hd64514da16af625c, 64'h7de1ce3ec600b27d, 64'h97742bfa39500785,
    64'h37e57a0934a9e321, 64'h0872c00e96058f5f, 64'h9a9291f9452ff389, 64'h1240421b117dc351,
    64'h179b86fb16a829ed, 64'hf773ae083f3cd908, 64'hc32304664f8ce10f, 64'h3bf48227de1ad114,
    64'h1e051eb805a697ad, 64'h70ef7848e5ff8346, 64'he7dc2e245cb0d7f3, 64'hf9ccdaee9f48ca62,
    64'h2ef082a2b4419ad3, 64'h8a9287ed4ecd5750, 64'h9f7b959d7c2ff1ba, 64'h1b86fb1047eee0a9,
    64'h342ac90ae166bfb4, 64'h9c28c8b1a92ab370, 64'h7248bbdc9faaf6c1, 64'h1a3b7cdd85269cfa,
    64'hcf3af94626a8c04f, 64'h7a4ba5bef4f2856c, 64'ha80dd551adc99bb8, 64'hd7cef340d2e894ba,
    64'h134c05ffd4928eba, 64'h78b5ec19a589ff89, 64'hd8d23f88cbd19231, 64'ha95a65c91e98558c,
    64'h0a996675f053aa80, 64'hf35d31427e2dce98, 64'h9985000bf5aefe7b, 64'h73ac3f7cc6a7d6e0,
    64'hc48e7406cc446de3, 64'hf919aa74e167dbbe, 64'h8b09e12fc48dbbcd, 64'h33b5f1fbafc21ead,
    64'hfbbf051f129c275d, 64'h3239b2a8ee124a62, 64'h8984d8d6b4a2ad6a, 64'he2293308df3acd2b,
    64'h2529297459fa7fac, 64'h36c72d90491e670f, 64'he7ca9d442ddae3b3, 64'h8fa38fa2a012ce0d,
    64'h5caac60bfad2c355, 64'ha92158609a2e1285, 64'h8a097df8fdb4c6cf, 64'h1f1b6f8230e90ff0,
    64'h8369b558bec7e569, 64'h2e9d4f7aabcb210d, 64'hafb7d767ac296c18, 64'h2f5cd5c2515d81c1,
    64'h45934465add6c676, 64'ha5a45e774fd55fc3, 64'hb4cb7e6e96d2a59d, 64'hfdc6635b7ec562b0,
    64'h1bcedbd2ea8b4bf9, 64'h0ab5b24bb7ccf99d, 64'h31aa59853645b444, 64'h9149c77d16594ff5,
    64'h77d9fee30ed21a67, 64'h12982d192e88015b, 64'hd45d1f788a6a1ef3, 64'h332d24e0edf8ca0a,
    64'h88c7695975b9d19b, 64'h065f29d44b168060, 64'hd2a2a94e28c99de3, 64'h8235595da56d3cd7,
    64'h4d58d451daa20b65, 64'h36a1edff55e32372, 64'hdf5c5c1e6b75c40b, 64'h85c8a6bf77ecf2d3,
    64'h7d72ca70ec2882f2, 64'hfe286fdc7db952ca, 64'h13e308d730603af4, 64'h7803625ac832d270,
    64'h920af03f31044bc6, 64'h1fe4f2d207fecc03, 64'h38537ef4067d59e9, 64'h0eca7ef2100d20fc,
    64'h0a6fe0e637366afc, 64'h9d52574f1a85c9e5, 64'hd0a0fdbd96ed75d2, 64'hb6785ac2254c0d92,
    64'h708122c30c97ff1f, 64'h3e265597b73bc11e, 64'hb3a870c781058225, 64'hd93d905b304c4ec6,
    64'h52ff676e213f6ccb, 64'hde7503df2ee1aed6, 64'hcc95a88b5c5fc05a, 64'h351d157d93a36b21,
    64'hf33702abc575fb08, 64'hedcec8d4e602f76d, 64'h210d869a4002a35a, 64'hed6debb5a777ff11,
    64'h4aa4ef159b20a5da, 64'h1248e5993f479e53, 64'h6afdd7979ed93e76, 64'h0048f115bbf8fcc9,
    64'h3c43dcc810f39b4c, 64'hd596e217217ba38d, 64'hf026411acc2ffc3f, 64'ha9bfe1a48496f61c,
    64'h3c5d0feeb403ffe6, 64'hf3cc4252ff0a0e4b, 64'h9287b23486699a23, 64'hfcb9175b7c6ad7f1,
    64'hd28a3ca6572757d0, 64'h9679f32c0d2f01f8, 64'h9aec761f1611e561, 64'h00d429298b4544fc,
    64'h08aa8292dcaff98f, 64'h36c88c6cf0188da2, 64'h674a34c8653e66b8, 64'h0e6316f1731e02b8,
    64'hd049743dfb30601e, 64'he99b74d4efa92d88, 64'ha41f9c33729e01ad, 64'he0a2c2031c01b13d,
    64'h04a396e2dfc4f61f, 64'hdb2556b846e68964, 64'ha5de683723f23704, 64'h456f750ec820ea4f,
    64'h47b81bb8dda336aa, 64'h7c0b4cab5dffb32e, 64'h020a4567a37ada75, 64'h66325b8ce0bc3890,
    64'h566e9b6d6a194d5e, 64'h53efbb71787c4049, 64'hee775a2e794219de, 64'ha65c279ca51a6a46,
    64'haac56091fcec9c38, 64'h0b34953b386ed0c4, 64'hde46839785d1b945, 64'h623a65d725974df2
  };

  // Rotate a 64-bit word left; a zero amount leaves the word as it is.
  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
    logic [6:0] rc;
    rc = 7'd64 - {1'b0, r};
    if (r == 6'd0) begin
      return x;
    end
    return (x << r) | (x >> rc);
  endfunction

endpackage

### rtl/rwbh_ram.sv
module rwbh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 48,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [Width-1:0]     wdata_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port, read-first: a read and a write to the same entry
  // return the old contents.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rwbh_ring_ctrl.sv
module rwbh_ring_ctrl #(
  parameter int unsigned Window = 48,
  localparam int unsigned AddrWidth = (Window > 1) ? $clog2(Window) : 1,
  localparam int unsigned FillWidth = $clog2(Window + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 restart_i,
  input  logic                 advance_i,
  output logic [AddrWidth-1:0] ram_addr_o,
  output rwbh_pkg::s1_t        s1_o
);

  import rwbh_pkg::*;

  localparam logic [AddrWidth-1:0] PosLast = AddrWidth'(Window - 1);
  localparam logic [FillWidth-1:0] FillMax = FillWidth'(Window);

  logic [AddrWidth-1:0] pos_q, pos_d, pos_start;
  logic [FillWidth-1:0] fill_q, fill_d, fill_start;
  logic                 drop_old;
  logic                 valid_q;
  logic [7:0]           byte_q;
  logic                 restart_q, drop_q, full_q;

  // A restart empties the window before this byte goes in.
  always_comb begin
    pos_start  = restart_i ? '0 : pos_q;
    fill_start = restart_i ? '0 : fill_q;
    drop_old   = (fill_start == FillMax);
    fill_d     = drop_old ? fill_start : fill_start + FillWidth'(1);
    pos_d      = (pos_start == PosLast) ? '0 : pos_start + AddrWidth'(1);
  end

  assign ram_addr_o = pos_start;

  // Ring position, fill count and the stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        pos_q  <= pos_d;
        fill_q <= fill_d;
      end
      if (accept_i) begin
        valid_q <= 1'b1;
      end else if (advance_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Item payload held for the hash stage.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      byte_q    <= data_byte_i;
      restart_q <= restart_i;
      drop_q    <= drop_old;
      full_q    <= (fill_d == FillMax);
    end
  end

  always_comb begin
    s1_o.valid     = valid_q;
    s1_o.data_byte = byte_q;
    s1_o.restart   = restart_q;
    s1_o.drop_old  = drop_q;
    s1_o.win_full  = full_q;
  end

endmodule

### rtl/rwbh_hash_core.sv
module rwbh_hash_core #(
  parameter int unsigned Window = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rwbh_pkg::s1_t s1_i,
  input  logic [7:0]    old_byte_i,
  input  logic [63:0]   seed_i,
  input  logic          out_ready_i,
  output logic          advance_o,
  output logic          out_valid_o,
  output logic [63:0]   hash_value_o,
  output logic          window_full_o
);

  import rwbh_pkg::*;

  localparam logic [5:0] RotAmt = 6'(Window % 64);

  logic [63:0] hash_q, hash_d, base;
  logic [63:0] cancel;
  logic        full_q, valid_q;

  assign advance_o = s1_i.valid && (!valid_q || out_ready_i);

  // New hash: rotate, xor in the entering byte, cancel the leaving one.
  always_comb begin
    base   = s1_i.restart ? seed_i : hash_q;
    cancel = s1_i.drop_old ? rotl64(BYTE_TABLE[old_byte_i], RotAmt) : '0;
    hash_d = rotl64(base, 6'd1) ^ BYTE_TABLE[s1_i.data_byte] ^ cancel;
  end

  // The result register doubles as the running hash.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (advance_o) begin
        hash_q  <= hash_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      full_q <= s1_i.win_full;
    end
  end

  assign out_valid_o   = valid_q;
  assign hash_value_o  = hash_q;
  assign window_full_o = full_q;

endmodule

### rtl/rolling_window_byte_hash.sv
// Rolling byte hash over the last WINDOW bytes of a stream.
// Input channel: one byte per transfer on data_byte_i, with restart_i set
// on the first byte of a new stream. Each input transfer gives exactly one
// result transfer on the output channel: hash_value_o, the 64-bit hash
// after this byte, and window_full_o, set once the hash covers exactly the
// last WINDOW bytes.
// Configuration channel: hash_seed_i is written on a cfg transfer and is
// loaded into the hash at the next restart byte. Write it only while idle.
// The input byte is registered in the ring stage, then in the result register;
// one byte per clock is taken while the receiver takes results. The leaving
// byte comes from the window memory, read in the cycle of the input transfer;
// the table lookups, rotations and xor fit in the single stage behind it.
// After reset the hash is zero, the window is empty and the seed is zero.
// When the receiver stalls, the result is held, one more byte is taken into
// the internal stage, and then in_ready_o drops until the result moves on.
module rolling_window_byte_hash #(
  parameter int unsigned WINDOW = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o,
  output logic        window_full_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] hash_seed_i
);

  import rwbh_pkg::*;

  localparam int unsigned AddrWidth = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic                 accept, advance;
  logic [AddrWidth-1:0] ram_addr;
  logic [7:0]           old_byte;
  logic [63:0]          seed_q;
  s1_t                  s1;

  // Seed register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i) begin
      seed_q <= hash_seed_i;
    end
  end

  // Input handshake: the stage takes a byte when empty or moving on.
  assign in_ready_o = !s1.valid || advance;
  assign accept     = in_valid_i && in_ready_o;

  rwbh_ring_ctrl #(
    .Window (WINDOW)
  ) u_ring_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .advance_i   (advance),
    .ram_addr_o  (ram_addr),
    .s1_o        (s1)
  );

  // Window memory: the old byte is read as the new one is written.
  rwbh_ram #(
    .Width (8),
    .Depth (WINDOW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept),
    .addr_i  (ram_addr),
    .wdata_i (data_byte_i),
    .rdata_o (old_byte)
  );

  rwbh_hash_core #(
    .Window (WINDOW)
  ) u_hash_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_i          (s1),
    .old_byte_i    (old_byte),
    .seed_i        (seed_q),
    .out_ready_i   (out_ready_i),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .hash_value_o  (hash_value_o),
    .window_full_o (window_full_o)
  );

`ifndef SYNTH
  // A restart byte never cancels a leaving byte.
  a_restart_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> !s1.drop_old)
    else $error("restart byte marked to cancel an old byte");

  // Cancelling only happens with a full window.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1.valid && s1.drop_old |-> s1.win_full)
    else $error("old byte cancelled while window not full");

  // Input is refused only when both the stage and the result are held.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1.valid && out_valid_o && !out_ready_i)
    else $error("input refused without back-pressure");
`endif

endmodule
